// ===== hdl/sine_tone_cadence_generator_assert.svh =====
// Assertion macros for the sine tone cadence generator.
// Used by sine_tone_cadence_generator.sv; needs a clock and reset in scope.
`ifndef SINE_TONE_CADENCE_GENERATOR_ASSERT_SVH
`define SINE_TONE_CADENCE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define STCG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STCG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/stcg_pkg.sv =====
// Package for the sine tone cadence generator: sizes, CSR indexes and the
// quarter-wave unsigned Q0.15 sine table built at elaboration. No dependencies.
package stcg_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int TABLE_SIZE      = 1 << TABLE_ADDR_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INC  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AMPLITUDE  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUSY_MODE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ON_LENGTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFF_LENGTH = 3'd4;

   localparam logic [31:0] PHASE_INC_RESET  = 32'd228170138;
   localparam logic [14:0] AMPLITUDE_RESET  = 15'd14000;
   localparam logic [15:0] ON_LENGTH_RESET  = 16'd2880;
   localparam logic [15:0] OFF_LENGTH_RESET = 16'd2800;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic [14:0] sine_table_type [TABLE_SIZE];

   // round(32767*sin(pi/2*(i+0.5)/TABLE_SIZE)) by a Q30 Taylor series
   function automatic logic [14:0] sine_entry(input int i);
      logic [63:0] frac;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      frac = 64'(2 * i + 1) << (29 - TABLE_ADDR_BITS);
      t    = (frac * HALF_PI_Q30) >> 30;
      t2   = (t * t) >> 30;
      term = t;
      sum  = t;
      term = ((term * t2) >> 30) / 6;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * t2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * t2) >> 30) / 42;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * t2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * t2) >> 30) / 110;
      sum  = (sum > term) ? sum - term : 64'd0;
      term = ((term * t2) >> 30) / 156;
      sum  = sum + term;
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   function automatic sine_table_type build_table();
      sine_table_type tbl;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tbl[i] = sine_entry(i);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_table();

endpackage

// ===== hdl/sine_tone_cadence_generator.sv =====
// Sine tone generator with on/off busy cadence, top level.
// Depends on stcg_pkg and sine_tone_cadence_generator_assert.svh.
//
// One transaction on req_ is one sample tick and yields exactly one rsp_
// transaction, through the stage 1 register and then the output register. The
// block takes one tick per cycle, sustained, whenever rsp_ is not stalled; the
// figure is set by the phase add and cadence compare done in the accept cycle.
// While req_active is 1 the sample is amplitude * sin(phase) from a
// quarter-wave table; in busy mode on_length tone samples alternate with
// off_length silent ones (phase held). req_active 0 gives silence and restarts
// phase and cadence. CSRs are written by csr_write/csr_index/csr_wdata and
// must only change while no transaction is in flight.
`include "sine_tone_cadence_generator_assert.svh"

module sine_tone_cadence_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_active,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [15:0]                    rsp_sample,
   output logic                                  rsp_tone_on,
   input  logic                                  csr_write,
   input  logic [stcg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [stcg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int PB = stcg_pkg::PHASE_BITS;
   localparam int AB = stcg_pkg::TABLE_ADDR_BITS;

   // CSRs
   logic [31:0] phase_inc_ff;
   logic [14:0] amplitude_ff;
   logic        busy_mode_ff;
   logic [15:0] on_length_ff;
   logic [15:0] off_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff  <= stcg_pkg::PHASE_INC_RESET;
         amplitude_ff  <= stcg_pkg::AMPLITUDE_RESET;
         busy_mode_ff  <= 1'b0;
         on_length_ff  <= stcg_pkg::ON_LENGTH_RESET;
         off_length_ff <= stcg_pkg::OFF_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            stcg_pkg::CSR_PHASE_INC:  phase_inc_ff  <= csr_wdata[31:0];
            stcg_pkg::CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[14:0];
            stcg_pkg::CSR_BUSY_MODE:  busy_mode_ff  <= csr_wdata[0];
            stcg_pkg::CSR_ON_LENGTH:  on_length_ff  <= csr_wdata[15:0];
            stcg_pkg::CSR_OFF_LENGTH: off_length_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic out_ready;
   logic s1_ready;
   logic req_accept;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;

   // generator state
   logic [PB-1:0] phase_acc_ff, phase_acc_in;
   logic [15:0]   cadence_ff, cadence_in;
   logic          pause_ff, pause_in;
   logic [15:0]   count_inc;
   logic          tone_in;

   assign count_inc = cadence_ff + 16'd1;

   always_comb begin
      phase_acc_in = phase_acc_ff;
      cadence_in   = cadence_ff;
      pause_in     = pause_ff;
      tone_in      = 1'b0;
      if (!req_active) begin
         phase_acc_in = '0;
         cadence_in   = '0;
         pause_in     = 1'b0;
      end else if (pause_ff) begin
         // pause ends on off_length regardless of busy_mode
         if (count_inc >= off_length_ff) begin
            cadence_in = '0;
            pause_in   = 1'b0;
         end else begin
            cadence_in = count_inc;
         end
      end else begin
         tone_in      = 1'b1;
         phase_acc_in = phase_acc_ff + PB'(phase_inc_ff);
         if (busy_mode_ff) begin
            if (count_inc >= on_length_ff) begin
               cadence_in = '0;
               pause_in   = (off_length_ff != 16'd0);
            end else begin
               cadence_in = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         cadence_ff   <= '0;
         pause_ff     <= 1'b0;
      end else if (req_accept) begin
         phase_acc_ff <= phase_acc_in;
         cadence_ff   <= cadence_in;
         pause_ff     <= pause_in;
      end
   end

   // stage 1: table address and sign from the pre-increment phase
   logic [AB-1:0] idx_ff, idx_in;
   logic          neg_ff;
   logic          tone_ff;
   logic [1:0]    quad;

   assign quad   = phase_acc_ff[PB-1 -: 2];
   assign idx_in = quad[0] ? ~phase_acc_ff[PB-3 -: AB] : phase_acc_ff[PB-3 -: AB];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         idx_ff  <= idx_in;
         neg_ff  <= quad[1];
         tone_ff <= tone_in;
      end
   end

   // stage 2: table read, scale, sign
   logic [14:0]        entry;
   logic [29:0]        product;
   logic [15:0]        mag;
   logic signed [15:0] sample_in;
   logic signed [15:0] sample_ff;
   logic               tone_out_ff;

   assign entry   = stcg_pkg::SINE_TABLE[idx_ff];
   assign product = 30'(amplitude_ff) * 30'(entry);
   assign mag     = {1'b0, product[29:15]};

   always_comb begin
      if (!tone_ff) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = -$signed(mag);
      end else begin
         sample_in = $signed(mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         sample_ff   <= sample_in;
         tone_out_ff <= tone_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_tone_on = tone_out_ff;

   // checks
   `STCG_ASSERT_SAME(a_silent_is_zero, rsp_valid && !rsp_tone_on, rsp_sample == 16'sd0,
      "silent sample is not zero")
   `STCG_ASSERT_SAME(a_no_min_value, rsp_valid, rsp_sample != 16'sh8000,
      "sample magnitude out of range")
   `STCG_ASSERT_NEXT(a_stop_clears, req_accept && !req_active,
      phase_acc_ff == '0 && cadence_ff == 16'd0 && !pause_ff,
      "inactive tick did not clear generator state")
   `STCG_ASSERT_NEXT(a_pause_holds_phase, req_accept && req_active && pause_ff,
      $stable(phase_acc_ff), "phase moved during cadence pause")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for sine_tone_cadence_generator: directed table plus random
// sample ticks, each response checked against a fixed value or a tone/cadence predictor kept here.
// Depends on stcg_pkg (CSR codes, sizes, register reset values) and the DUT.
module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_TICKS   = 2000;
   localparam int TABLE_ADDR_BITS = stcg_pkg::TABLE_ADDR_BITS;
   localparam int TABLE_SIZE     = stcg_pkg::TABLE_SIZE;
   localparam int CSR_INDEX_BITS = stcg_pkg::CSR_INDEX_BITS;
   localparam int CSR_DATA_BITS  = stcg_pkg::CSR_DATA_BITS;
   localparam int LUT_SHIFT      = stcg_pkg::PHASE_BITS - 2 - TABLE_ADDR_BITS;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               tone_on;
   } tone_result_type;

   typedef enum logic [1:0] {ROW_TICK, ROW_KNOWN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic                      active;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      tone_result_type           known;
   } script_row_type;

   localparam int DIRECTED_ROWS = 42;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid  = 1'b0;
   logic                      req_stall;
   logic                      req_active = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall  = 1'b0;
   logic signed [15:0]        rsp_sample;
   logic                      rsp_tone_on;
   logic                      csr_write  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = stcg_pkg::CSR_PHASE_INC;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   sine_tone_cadence_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_active  (req_active),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_sample  (rsp_sample),
      .rsp_tone_on (rsp_tone_on),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state and register shadow
   logic [14:0] quarter_wave [TABLE_SIZE];
   logic [31:0] tone_phase;
   logic [15:0] cadence_count;
   logic        in_silence;
   logic [31:0] cfg_phase_step;
   logic [14:0] cfg_amplitude;
   logic        cfg_busy;
   logic [15:0] cfg_on_len;
   logic [15:0] cfg_off_len;

   tone_result_type pending_results [$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              quiet_cycles   = 0;
   script_row_type  directed_script [DIRECTED_ROWS];

   // Q30 Taylor series of sin at the center of quarter-table slot i
   function automatic logic [14:0] taylor_entry(input int i);
      longint unsigned frac;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      frac = 64'(2 * i + 1) << (29 - TABLE_ADDR_BITS);
      t    = (frac * Q30_HALF_PI) >> 30;
      t2   = (t * t) >> 30;
      term = t;
      sum  = t;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   function automatic logic signed [15:0] tone_level(input logic [31:0] phase,
                                                      input logic [14:0] amp);
      int unsigned        top;
      int unsigned        idx;
      int unsigned        quad;
      logic [29:0]        prod;
      logic signed [15:0] level;
      top  = phase >> LUT_SHIFT;
      idx  = top & (TABLE_SIZE - 1);
      quad = (top >> TABLE_ADDR_BITS) & 3;
      if (quad[0]) begin
         idx = TABLE_SIZE - 1 - idx;
      end
      prod  = 30'(amp) * 30'(quarter_wave[idx]);
      level = {1'b0, prod[29:15]};
      if (quad[1]) begin
         level = -level;
      end
      return level;
   endfunction

   task automatic predict_tick(input logic active, output tone_result_type res);
      res = '0;
      if (!active) begin
         tone_phase    = '0;
         cadence_count = '0;
         in_silence    = 1'b0;
      end else if (in_silence) begin
         cadence_count = cadence_count + 16'd1;
         if (cadence_count >= cfg_off_len) begin
            cadence_count = '0;
            in_silence    = 1'b0;
         end
      end else begin
         res.sample  = tone_level(tone_phase, cfg_amplitude);
         res.tone_on = 1'b1;
         tone_phase  = tone_phase + cfg_phase_step;
         if (cfg_busy) begin
            cadence_count = cadence_count + 16'd1;
            // on_length of zero behaves like one: the compare always hits
            if (cadence_count >= cfg_on_len) begin
               cadence_count = '0;
               if (cfg_off_len != 16'd0) begin
                  in_silence = 1'b1;
               end
            end
         end
      end
   endtask

   function automatic script_row_type row_tick(input logic active);
      script_row_type r;
      r        = '0;
      r.kind   = ROW_TICK;
      r.active = active;
      return r;
   endfunction

   function automatic script_row_type row_known(input logic active,
                                                input logic signed [15:0] sample,
                                                input logic tone_on);
      script_row_type r;
      r               = '0;
      r.kind          = ROW_KNOWN;
      r.active        = active;
      r.known.sample  = sample;
      r.known.tone_on = tone_on;
      return r;
   endfunction

   function automatic script_row_type row_csr(input logic [CSR_INDEX_BITS-1:0] index,
                                              input logic [CSR_DATA_BITS-1:0] value);
      script_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // One sample tick; valid is only lowered in the idle gap, never in the accept step
   task automatic send_tick(input logic active, input logic typed,
                            input tone_result_type typed_res);
      tone_result_type model_res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_active <= active;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_tick(active, model_res);
      pending_results.push_back(typed ? typed_res : model_res);
   endtask

   // Hold off new ticks until every response is back and the pipe is empty
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Raises csr_write; the caller lowers it after the last register of a group
   task automatic csr_store(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         stcg_pkg::CSR_PHASE_INC:  cfg_phase_step = value;
         stcg_pkg::CSR_AMPLITUDE:  cfg_amplitude  = value[14:0];
         stcg_pkg::CSR_BUSY_MODE:  cfg_busy       = value[0];
         stcg_pkg::CSR_ON_LENGTH:  cfg_on_len     = value[15:0];
         stcg_pkg::CSR_OFF_LENGTH: cfg_off_len    = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] pick_length();
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return 32'hFFFF;
         2:       return $urandom;
         default: return $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [31:0] pick_phase_step();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_amplitude();
      case ($urandom_range(5))
         0:       return 32'd0;
         1:       return 32'h7FFF;
         default: return $urandom;  // upper bits must be dropped
      endcase
   endfunction

   task automatic write_random_settings();
      wait_drained();
      if ($urandom_range(1)) csr_store(stcg_pkg::CSR_PHASE_INC, pick_phase_step());
      if ($urandom_range(1)) csr_store(stcg_pkg::CSR_AMPLITUDE, pick_amplitude());
      if ($urandom_range(1)) csr_store(stcg_pkg::CSR_BUSY_MODE, $urandom);
      if ($urandom_range(1)) csr_store(stcg_pkg::CSR_ON_LENGTH, pick_length());
      if ($urandom_range(1)) csr_store(stcg_pkg::CSR_OFF_LENGTH, pick_length());
      csr_write <= 1'b0;
   endtask

   // Response side: random stall and in-order compare
   always @(posedge clock) begin
      tone_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response sample=%0d tone_on=%0b with nothing expected",
                                      rsp_sample, rsp_tone_on));
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_sample !== exp_res.sample) begin
               report_mismatch($sformatf("sample %0d, expected %0d",
                                         rsp_sample, exp_res.sample));
            end
            if (rsp_tone_on !== exp_res.tone_on) begin
               report_mismatch($sformatf("tone_on %0b, expected %0b",
                                         rsp_tone_on, exp_res.tone_on));
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int ticks_done;
      int burst;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         quarter_wave[i] = taylor_entry(i);
      end
      cfg_phase_step = stcg_pkg::PHASE_INC_RESET;
      cfg_amplitude  = stcg_pkg::AMPLITUDE_RESET;
      cfg_busy       = 1'b0;
      cfg_on_len     = stcg_pkg::ON_LENGTH_RESET;
      cfg_off_len    = stcg_pkg::OFF_LENGTH_RESET;
      tone_phase     = '0;
      cadence_count  = '0;
      in_silence     = 1'b0;

      directed_script = '{
         row_known(1'b0, 16'sd0, 1'b0),           // inactive right out of reset
         row_tick(1'b1),                          // reset registers, phase zero
         row_tick(1'b1),
         row_known(1'b0, 16'sd0, 1'b0),
         row_csr(stcg_pkg::CSR_PHASE_INC, 32'h4000_0000),  // quarter turn per tick
         row_csr(stcg_pkg::CSR_AMPLITUDE, 32'hFFFF_FFFF),  // wide write keeps 15 bits
         row_tick(1'b1),
         row_tick(1'b1),
         row_tick(1'b1),
         row_tick(1'b1),
         row_tick(1'b1),
         row_csr(stcg_pkg::CSR_PHASE_INC, 32'hFFFF_FFFF),
         row_csr(stcg_pkg::CSR_AMPLITUDE, 32'd0),
         row_known(1'b1, 16'sd0, 1'b1),           // zero amplitude is still tone
         row_known(1'b1, 16'sd0, 1'b1),
         row_known(1'b0, 16'sd0, 1'b0),
         row_csr(stcg_pkg::CSR_AMPLITUDE, 32'h7FFF),
         row_csr(stcg_pkg::CSR_PHASE_INC, 32'h0080_0000),
         row_csr(stcg_pkg::CSR_BUSY_MODE, 32'd1),
         row_csr(stcg_pkg::CSR_ON_LENGTH, 32'd0),  // zero on length acts as one
         row_csr(stcg_pkg::CSR_OFF_LENGTH, 32'd2),
         row_tick(1'b1),
         row_known(1'b1, 16'sd0, 1'b0),
         row_known(1'b1, 16'sd0, 1'b0),
         row_tick(1'b1),
         row_known(1'b1, 16'sd0, 1'b0),
         row_csr(stcg_pkg::CSR_BUSY_MODE, 32'd0),  // pause still runs out
         row_known(1'b1, 16'sd0, 1'b0),
         row_tick(1'b1),
         row_tick(1'b1),
         row_csr(stcg_pkg::CSR_BUSY_MODE, 32'd1),
         row_csr(stcg_pkg::CSR_ON_LENGTH, 32'd4),
         row_csr(stcg_pkg::CSR_OFF_LENGTH, 32'd0), // period ends with no pause
         row_tick(1'b1),
         row_tick(1'b1),
         row_csr(stcg_pkg::CSR_ON_LENGTH, 32'd1),  // lowered mid-period
         row_tick(1'b1),
         row_tick(1'b1),
         row_csr(stcg_pkg::CSR_ON_LENGTH, 32'hFFFF),
         row_csr(stcg_pkg::CSR_OFF_LENGTH, 32'hFFFF),
         row_tick(1'b1),
         row_known(1'b0, 16'sd0, 1'b0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_script[r].kind == ROW_CSR) begin
            if (r == 0 || directed_script[r-1].kind != ROW_CSR) begin
               wait_drained();
            end
            csr_store(directed_script[r].index, directed_script[r].value);
            if (r == DIRECTED_ROWS - 1) begin
               csr_write <= 1'b0;
            end else if (directed_script[r+1].kind != ROW_CSR) begin
               csr_write <= 1'b0;
            end
         end else begin
            send_tick(directed_script[r].active, directed_script[r].kind == ROW_KNOWN,
                      directed_script[r].known);
         end
      end

      // three idle profiles: slow receiver, slow sender, then back-to-back
      for (int p = 0; p < 3; p++) begin
         send_idle_pct  = (p == 0) ? 13 : (p == 1) ? 71 : 0;
         recv_stall_pct = (p == 0) ? 71 : (p == 1) ? 13 : 0;
         ticks_done = 0;
         while (ticks_done < RANDOM_TICKS / 3) begin
            write_random_settings();
            burst = $urandom_range(20, 80);
            for (int k = 0; k < burst; k++) begin
               if ($urandom_range(63) == 0) begin
                  wait_drained();
               end
               send_tick($urandom_range(15) != 0, 1'b0, '0);
            end
            ticks_done += burst;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
